// File: rtl/circular_queue_with_dump_assert.svh
// Assertion macros shared by the circular queue RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CIRCULAR_QUEUE_WITH_DUMP_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CQ_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define CQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/cq_pkg.sv
// Shared types and constants for the circular queue with dump.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_DISP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_DISP
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  value;
  } op_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } res_t;

endpackage

// File: rtl/cq_front.sv
// Front end: accepts items, decodes the command and buffers ops.
// Depends on cq_pkg; feeds cq_back through a two-entry op queue.
`timescale 1ns / 1ps

module cq_front import cq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     op_valid,
  output op_t                      op,
  input  logic                     op_take
);

  op_t        q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, store, take;
  op_t        new_op;

  assign in_full  = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rp_r];

  assign accept = in_push && !in_full;
  // unused command code is accepted and dropped here
  assign store  = accept && (cmd_t'(in_command) != CMD_NONE);
  assign take   = op_take && op_valid;

  always_comb begin
    new_op.value = in_value;
    case (cmd_t'(in_command))
      CMD_ENQ: new_op.kind = OP_ENQ;
      CMD_DEQ: new_op.kind = OP_DEQ;
      default: new_op.kind = OP_DISP;
    endcase
  end

  always_comb begin
    wp_nxt  = store ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(store) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      q_r[wp_r] <= new_op;
    end
  end

endmodule

// File: rtl/cq_back.sv
// Back end: executes ops against the entry store and the index registers.
// Depends on cq_pkg and the assertion header; pushes results into cq_resq.
`timescale 1ns / 1ps
`include "circular_queue_with_dump_assert.svh"

module cq_back import cq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             op_valid,
  input  op_t              op,
  output logic             op_take,
  input  logic             res_full,
  output logic             res_push,
  output res_t             res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_DISP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   eff_cap;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic               empty_r, empty_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   succ_head, succ_tail, succ_ptr;
  logic               done;

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rd_data_r;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;

  function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] i,
                                            input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] n;
    n = CAP_W'(i) + CAP_W'(1);
    return (n >= cap) ? '0 : n[IDX_W-1:0];
  endfunction

  // out-of-range capacity clamps to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      eff_cap = CAP_W'(DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign succ_head = succ(head_r, eff_cap);
  assign succ_tail = succ(tail_r, eff_cap);
  assign succ_ptr  = succ(ptr_r, eff_cap);
  assign done      = (ptr_r == tail_r) || (cnt_r == IDX_W'(DEPTH - 1));

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    op_take    = 1'b0;
    res_push   = 1'b0;
    res.status = ST_OK;
    res.data   = '0;
    res.last   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    wr_en      = 1'b0;
    wr_addr    = succ_tail;
    case (state_r)
      S_IDLE: begin
        if (op_valid && !res_full) begin
          op_take = 1'b1;
          case (op.kind)
            OP_ENQ: begin
              res_push = 1'b1;
              if (empty_r) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (succ_tail == head_r) begin
                res.status = ST_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = succ_tail;
              end
            end
            OP_DEQ: begin
              if (empty_r) begin
                res_push   = 1'b1;
                res.status = ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DEQ;
                if (head_r == tail_r) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  empty_nxt = 1'b1;
                end else begin
                  head_nxt = succ_head;
                end
              end
            end
            OP_DISP: begin
              if (empty_r) begin
                res_push   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                ptr_nxt   = head_r;
                cnt_nxt   = '0;
                state_nxt = S_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        res.data = rd_data_r;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        res.data = rd_data_r;
        res.last = done;
        if (!res_full) begin
          res_push = 1'b1;
          if (done) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = succ_ptr;
            cnt_nxt = cnt_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = succ_ptr;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
      ptr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // entry store: never read and written in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= op.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  `CQ_ASSERT_IMPL(a_empty_idx_zero, empty_r, head_r == '0 && tail_r == '0)
  `CQ_ASSERT_IMPL(a_no_push_when_full, res_push, !res_full)
  `CQ_ASSERT_NEXT(a_deq_reads, op_take && op.kind == OP_DEQ && !empty_r, state_r == S_DEQ)

endmodule

// File: rtl/cq_resq.sv
// Result queue: two-entry buffer between the back end and the output ports.
// Depends on cq_pkg.
`timescale 1ns / 1ps

module cq_resq import cq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_push,
  input  res_t                     res,
  output logic                     res_full,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  res_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;
  res_t       head;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign head      = q_r[rp_r];
  assign out_status = head.status;
  assign out_data   = head.data;
  assign out_last   = head.last;

  assign wr = res_push && !res_full;
  assign rd = out_pop && !out_empty;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= res;
    end
  end

endmodule

// File: rtl/circular_queue_with_dump.sv
// Circular queue of signed words with a dump command; capacity set by cfg_data.
// Results go via op queue, back end and result queue; dequeue/dump add the store read.
// Dequeue adds S_DEQ; a dump reads one entry a cycle in S_DISP while res_full is low.
// Reset (rst_n low, synchronous): queue empty, indices 0, capacity 64; no clearing pass.
// Depends on cq_pkg, cq_front, cq_back, cq_resq.
`timescale 1ns / 1ps

module circular_queue_with_dump import cq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration: capacity register; user writes it when the block is idle, unchecked
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  // input item channel
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  // result item channel
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  // front -> back op handoff
  logic op_valid;
  op_t  op;
  logic op_take;

  // back -> result queue handoff
  logic res_full;
  logic res_push;
  res_t res;

  // Front end decodes each item and parks it in a two-entry op queue (unused
  // codes are dropped), so up to two ops can come in while the back end walks a dump.
  cq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_value   (in_value),
    .op_valid   (op_valid),
    .op         (op),
    .op_take    (op_take)
  );

  // Back end owns the entry store (one port per cycle, registered read),
  // the head/tail indices and the capacity register. A dump reads one
  // entry per cycle and stalls whenever the result queue is full.
  cq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // Result queue decouples the consumer: results wait here while the
  // back end carries on with the next op.
  cq_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

// File: tb/tb.sv
// Self-checking bench for circular_queue_with_dump: stalls, capacity changes, dumps.
// Needs cq_pkg and the circular_queue_with_dump RTL; no files and no arguments.
`timescale 1ns / 1ps

module tb;
  import cq_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int QUIET_LIMIT = 5000;  // cycles without any accept or pop before giving up
  localparam int STALL_LEN   = 400;   // receiver hold-off used to fill the block

  // one input item as the sender offers it
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
  } cq_item_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CAP_W-1:0]         cfg_data   = '0;
  logic                     in_push    = 1'b0;
  logic                     in_full;
  logic [1:0]               in_command = CMD_NONE;
  logic signed [DATA_W-1:0] in_value   = '0;
  logic                     out_empty;
  logic                     out_pop    = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;

  // items waiting to be offered, and results the queue still owes us
  cq_item_t cmd_backlog[$];
  res_t     due_results[$];

  // shadow copy of the queue, updated at the edge where an item is taken
  logic signed [DATA_W-1:0] m_store [DEPTH];
  logic [IDX_W-1:0]         m_head  = '0;
  logic [IDX_W-1:0]         m_tail  = '0;
  logic                     m_empty = 1'b1;
  logic [CAP_W-1:0]         m_cap   = CAP_RESET;

  // stall knobs, written by the sequencer on the falling edge only
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned stall_ticket = 0;
  int unsigned stall_seen   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet        = 0;
  int unsigned errors       = 0;

  circular_queue_with_dump i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_value   (in_value),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    for (int i = 0; i < DEPTH; i++) m_store[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Shadow queue
  // ---------------------------------------------------------------------------

  // a register value of 0 behaves as 1, anything above DEPTH as DEPTH
  function automatic int unsigned live_capacity();
    if (m_cap == '0) return 1;
    if (m_cap > DEPTH) return DEPTH;
    return 32'(m_cap);
  endfunction

  // wrap happens as soon as index+1 reaches the live capacity, even if the
  // index is already past it after a capacity drop
  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] slot);
    int unsigned n;
    n = slot + 1;
    return (n >= live_capacity()) ? '0 : IDX_W'(n);
  endfunction

  // apply one accepted item to the shadow queue and queue up its results
  function automatic void apply_to_shadow(cq_item_t it);
    res_t             r;
    logic [IDX_W-1:0] slot;
    bit               done;
    r.status = ST_OK;
    r.data   = '0;
    r.last   = 1'b1;
    case (it.cmd)
      CMD_ENQ: begin
        if (m_empty) begin
          // first entry always lands in slot 0
          m_head     = '0;
          m_tail     = '0;
          m_store[0] = it.value;
          m_empty    = 1'b0;
        end else if (next_slot(m_tail) == m_head) begin
          r.status = ST_OVERFLOW;
        end else begin
          m_tail          = next_slot(m_tail);
          m_store[m_tail] = it.value;
        end
        due_results.push_back(r);
      end
      CMD_DEQ: begin
        if (m_empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = m_store[m_head];
          if (m_head == m_tail) begin
            m_head  = '0;
            m_tail  = '0;
            m_empty = 1'b1;
          end else begin
            m_head = next_slot(m_head);
          end
        end
        due_results.push_back(r);
      end
      CMD_DISP: begin
        if (m_empty) begin
          r.status = ST_EMPTY;
          due_results.push_back(r);
        end else begin
          // walk head to tail; after a capacity drop the tail may never be
          // reached, so the walk stops at DEPTH results
          slot = m_head;
          for (int k = 0; k < DEPTH; k++) begin
            done   = (slot == m_tail) || (k + 1 >= DEPTH);
            r.data = m_store[slot];
            r.last = done;
            due_results.push_back(r);
            if (done) break;
            slot = next_slot(slot);
          end
        end
      end
      default: ;  // unused command: no result, no state change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog head; once offered, an item stays up until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_p
    cq_item_t taken;
    bit       offer;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        taken = cmd_backlog.pop_front();
        apply_to_shadow(taken);
      end
      offer = (cmd_backlog.size() != 0) &&
              ((in_push && in_full) || ($urandom_range(99) >= tx_idle_pct));
      in_push <= offer;
      if (offer) begin
        in_command <= cmd_backlog[0].cmd;
        in_value   <= cmd_backlog[0].value;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each popped result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_p
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d data %0d last %0d",
                 $time, out_status, out_data, out_last);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_data !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, out_data);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          errors++;
        end
      end
    end
    // a new ticket from the sequencer starts a long hold-off
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (stall_ticket != stall_seen) begin
      stall_seen <= stall_ticket;
      hold_left  <= STALL_LEN;
      out_pop    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: only counts while work is outstanding and nothing moves
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : dog_p
    if (!rst_n || cfg_we || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cmd_backlog.size() == 0 && due_results.size() == 0)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers (all run on the falling edge, except the register write)
  // ---------------------------------------------------------------------------
  task automatic add_item(cmd_t cmd, logic signed [DATA_W-1:0] value);
    cq_item_t it;
    it.cmd   = cmd;
    it.value = value;
    cmd_backlog.push_back(it);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // mostly enqueue/dequeue with the given bias, some dumps, a few unused codes
  task automatic add_random_item(int unsigned enq_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)
      add_item(CMD_NONE, pick_value());
    else if (r < 11)
      add_item(CMD_DISP, pick_value());
    else if ($urandom_range(99) < enq_pct)
      add_item(CMD_ENQ, pick_value());
    else
      add_item(CMD_DEQ, pick_value());
  endtask

  // bursts that push the fill level up or down, so full and empty both come up
  task automatic random_run(int count);
    int left;
    int len;
    int unsigned enq_pct;
    left = count;
    while (left > 0) begin
      len = $urandom_range(20, 4);
      if (len > left) len = left;
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      repeat (len) add_random_item(enq_pct);
      left -= len;
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(negedge clk);
  endtask

  // register write only with the block idle; extra cycles cover an unused
  // command still in flight after the last result
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (8) @(negedge clk);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    m_cap    <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin tx_idle_pct = 28; rx_idle_pct = 52; end
      1: begin tx_idle_pct = 52; rx_idle_pct = 28; end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_p
    logic [CAP_W-1:0] caps [12];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(0);

    // directed: empty-queue answers, extreme words, unused code, simple dumps
    add_item(CMD_DEQ,  '0);
    add_item(CMD_DISP, '0);
    add_item(CMD_NONE, 32'sh7fff_ffff);
    add_item(CMD_ENQ,  32'sh7fff_ffff);
    add_item(CMD_ENQ,  32'sh8000_0000);
    add_item(CMD_ENQ,  '0);
    add_item(CMD_ENQ,  -1);
    add_item(CMD_DISP, -1);
    add_item(CMD_NONE, '0);
    repeat (4) add_item(CMD_DEQ, 32'sh5555_5555);
    add_item(CMD_DEQ,  '0);
    add_item(CMD_ENQ,  32'sh5555_5555);
    add_item(CMD_DISP, '0);
    add_item(CMD_DEQ,  '0);
    add_item(CMD_DISP, '0);

    // capacity of one: second enqueue overflows at once
    set_capacity(7'd1);
    add_item(CMD_ENQ,  32'shaaaa_aaaa);
    add_item(CMD_ENQ,  32'sh0000_0001);
    add_item(CMD_DISP, '0);
    add_item(CMD_DEQ,  '0);
    add_item(CMD_DEQ,  '0);

    // fill all DEPTH slots, overflow, full dump; every slot is written from here on
    set_capacity(7'd64);
    repeat (DEPTH) add_item(CMD_ENQ, $urandom);
    add_item(CMD_ENQ,  $urandom);
    add_item(CMD_DISP, $urandom);

    // shrink while full: tail is out of reach, dump stops at DEPTH results,
    // dequeues wrap early, then an enqueue wraps the tail back into range
    set_capacity(7'd8);
    add_item(CMD_DISP, '0);
    repeat (10) add_item(CMD_DEQ, '0);
    add_item(CMD_ENQ,  32'sh1234_5678);
    add_item(CMD_DISP, '0);
    set_capacity(7'd127);
    add_item(CMD_DISP, '0);

    caps[0]  = 7'd0;
    caps[1]  = 7'd2;
    caps[2]  = 7'($urandom_range(16, 3));
    caps[3]  = 7'd64;
    caps[4]  = 7'd127;
    caps[5]  = 7'($urandom_range(63, 17));
    caps[6]  = 7'd1;
    caps[7]  = 7'($urandom_range(126, 65));
    caps[8]  = 7'($urandom_range(8, 2));
    caps[9]  = 7'd64;
    caps[10] = 7'd0;
    caps[11] = 7'($urandom_range(40, 3));

    for (int p = 0; p < 12; p++) begin
      set_capacity(caps[p]);
      set_idling(p / 4);
      if (p == 4) begin
        // back-pressure: receiver holds off while the sender keeps feeding
        stall_ticket = stall_ticket + 1;
        repeat (70) add_random_item(80);
        wait_drained();
      end
      if (p == 6) begin
        // sender stops until every owed result is back, then resumes
        random_run(12);
        wait_drained();
        random_run(13);
      end else begin
        random_run(25);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
